// File: rtl/core/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg: shared types, codes and microcode table of the RC4 cipher unit.
// Holds the control word layout, the step addresses and the microprogram.
// ----------------------------------------------------------------------------
`default_nettype none

package rc4_pkg;

    localparam int unsigned PERM_DEPTH = 256;
    localparam int unsigned PERM_AW    = 8;

    // Item kinds carried on the input channel.
    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_SCHED = 2'd1,
        KIND_DATA  = 2'd2
    } kind_t;

    // Microprogram step addresses.
    typedef enum logic [3:0] {
        ST_DISPATCH,
        ST_KS_SETUP,
        ST_KS_FILL,
        ST_KS_RD,
        ST_KS_J,
        ST_KS_RDJ,
        ST_KS_WI,
        ST_KS_WJ,
        ST_KS_END,
        ST_C_I,
        ST_C_J,
        ST_C_WI,
        ST_C_WJ,
        ST_C_OUT,
        ST_U_OUT
    } step_t;

    typedef enum logic [2:0] {
        SQ_NEXT,
        SQ_GOTO,
        SQ_LOOP,
        SQ_DISPATCH,
        SQ_WAIT
    } seq_op_t;

    typedef enum logic [2:0] {
        RA_I,
        RA_I_INC,
        RA_J,
        RA_J_SUM,
        RA_T
    } ra_sel_t;

    typedef enum logic {
        WA_I,
        WA_J
    } wa_sel_t;

    typedef enum logic [1:0] {
        WD_I,
        WD_RD,
        WD_SI
    } wd_sel_t;

    typedef enum logic [1:0] {
        I_HOLD,
        I_INC,
        I_CLR
    } i_op_t;

    typedef enum logic [1:0] {
        J_HOLD,
        J_CLR,
        J_KS,
        J_CIPH
    } j_op_t;

    typedef enum logic [1:0] {
        K_HOLD,
        K_CLR,
        K_INC
    } k_op_t;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_CIPHER,
        OUT_PLAIN
    } out_sel_t;

    typedef struct packed {
        seq_op_t  seq;
        step_t    target;
        logic     take;
        logic     s_re;
        ra_sel_t  ra;
        logic     s_we;
        wa_sel_t  wa;
        wd_sel_t  wd;
        logic     k_re;
        i_op_t    i_op;
        j_op_t    j_op;
        k_op_t    k_op;
        logic     si_ld;
        logic     sj_ld;
        logic     set_keyed;
        out_sel_t out_sel;
    } ctrl_t;

    typedef struct packed {
        logic i_last;
        logic keyed;
        logic out_free;
    } stat_t;

    // The microprogram: one control word per step.
    function automatic ctrl_t ucode(step_t s);
        ctrl_t c;
        c = '{seq: SQ_GOTO, target: ST_DISPATCH, take: 1'b0, s_re: 1'b0, ra: RA_I,
              s_we: 1'b0, wa: WA_I, wd: WD_I, k_re: 1'b0, i_op: I_HOLD,
              j_op: J_HOLD, k_op: K_HOLD, si_ld: 1'b0, sj_ld: 1'b0,
              set_keyed: 1'b0, out_sel: OUT_NONE};
        case (s)
            ST_DISPATCH:
            begin
                c.seq  = SQ_DISPATCH;
                c.take = 1'b1;
            end
            ST_KS_SETUP:
            begin
                c.seq  = SQ_NEXT;
                c.i_op = I_CLR;
                c.j_op = J_CLR;
                c.k_op = K_CLR;
            end
            ST_KS_FILL:
            begin
                c.seq    = SQ_LOOP;
                c.target = ST_KS_FILL;
                c.s_we   = 1'b1;
                c.wa     = WA_I;
                c.wd     = WD_I;
                c.i_op   = I_INC;
            end
            ST_KS_RD:
            begin
                c.seq  = SQ_NEXT;
                c.s_re = 1'b1;
                c.ra   = RA_I;
                c.k_re = 1'b1;
            end
            ST_KS_J:
            begin
                c.seq   = SQ_NEXT;
                c.j_op  = J_KS;
                c.si_ld = 1'b1;
            end
            ST_KS_RDJ:
            begin
                c.seq  = SQ_NEXT;
                c.s_re = 1'b1;
                c.ra   = RA_J;
            end
            ST_KS_WI:
            begin
                c.seq  = SQ_NEXT;
                c.s_we = 1'b1;
                c.wa   = WA_I;
                c.wd   = WD_RD;
            end
            ST_KS_WJ:
            begin
                c.seq    = SQ_LOOP;
                c.target = ST_KS_RD;
                c.s_we   = 1'b1;
                c.wa     = WA_J;
                c.wd     = WD_SI;
                c.i_op   = I_INC;
                c.k_op   = K_INC;
            end
            ST_KS_END:
            begin
                c.seq       = SQ_GOTO;
                c.target    = ST_DISPATCH;
                c.i_op      = I_CLR;
                c.j_op      = J_CLR;
                c.set_keyed = 1'b1;
            end
            ST_C_I:
            begin
                c.seq  = SQ_NEXT;
                c.s_re = 1'b1;
                c.ra   = RA_I_INC;
                c.i_op = I_INC;
            end
            ST_C_J:
            begin
                c.seq   = SQ_NEXT;
                c.s_re  = 1'b1;
                c.ra    = RA_J_SUM;
                c.j_op  = J_CIPH;
                c.si_ld = 1'b1;
            end
            ST_C_WI:
            begin
                c.seq   = SQ_NEXT;
                c.s_we  = 1'b1;
                c.wa    = WA_I;
                c.wd    = WD_RD;
                c.sj_ld = 1'b1;
            end
            ST_C_WJ:
            begin
                c.seq  = SQ_NEXT;
                c.s_we = 1'b1;
                c.wa   = WA_J;
                c.wd   = WD_SI;
                c.s_re = 1'b1;
                c.ra   = RA_T;
            end
            ST_C_OUT:
            begin
                c.seq     = SQ_WAIT;
                c.target  = ST_DISPATCH;
                c.out_sel = OUT_CIPHER;
            end
            ST_U_OUT:
            begin
                c.seq     = SQ_WAIT;
                c.target  = ST_DISPATCH;
                c.out_sel = OUT_PLAIN;
            end
            default:
            begin
                c.seq    = SQ_GOTO;
                c.target = ST_DISPATCH;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/rc4_ram.sv
// ----------------------------------------------------------------------------
// rc4_ram: generic single-write, single-read RAM with registered read.
// A read of the address being written returns the new data.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                                         clk,
    input  wire logic                                         we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                             wdata,
    input  wire logic                                         re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/rc4_sequencer.sv
// ----------------------------------------------------------------------------
// rc4_sequencer: step counter and microcode table of the RC4 cipher unit.
// Issues one control word per cycle and resolves the conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_sequencer (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_accept,
    input  wire logic [1:0]     kind,
    input  wire rc4_pkg::stat_t stat,
    output rc4_pkg::ctrl_t      ctrl
);

    rc4_pkg::step_t step_reg;
    rc4_pkg::step_t step_next;
    rc4_pkg::step_t step_inc;

    assign ctrl     = rc4_pkg::ucode(step_reg);
    assign step_inc = rc4_pkg::step_t'(step_reg + 4'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= rc4_pkg::ST_DISPATCH;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_comb
    begin
        step_next = step_reg;
        case (ctrl.seq)
            rc4_pkg::SQ_NEXT:
            begin
                step_next = step_inc;
            end
            rc4_pkg::SQ_GOTO:
            begin
                step_next = ctrl.target;
            end
            rc4_pkg::SQ_LOOP:
            begin
                step_next = stat.i_last ? step_inc : ctrl.target;
            end
            rc4_pkg::SQ_DISPATCH:
            begin
                if (in_accept)
                begin
                    case (rc4_pkg::kind_t'(kind))
                        rc4_pkg::KIND_SCHED:
                        begin
                            step_next = rc4_pkg::ST_KS_SETUP;
                        end
                        rc4_pkg::KIND_DATA:
                        begin
                            step_next = stat.keyed ? rc4_pkg::ST_C_I : rc4_pkg::ST_U_OUT;
                        end
                        default:
                        begin
                            step_next = step_reg;
                        end
                    endcase
                end
            end
            rc4_pkg::SQ_WAIT:
            begin
                step_next = stat.out_free ? ctrl.target : step_reg;
            end
            default:
            begin
                step_next = rc4_pkg::ST_DISPATCH;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/rc4_datapath.sv
// ----------------------------------------------------------------------------
// rc4_datapath: permutation and key memories, stream indices and result stage.
// Every action is selected by the current control word.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_datapath #(
    parameter int unsigned KEY_BYTES = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire rc4_pkg::ctrl_t ctrl,
    input  wire logic           in_accept,
    input  wire logic [1:0]     kind,
    input  wire logic [7:0]     key_index,
    input  wire logic [7:0]     byte_value,
    input  wire logic [8:0]     key_length,
    input  wire logic           out_ready,
    output logic                out_valid,
    output logic      [7:0]     data_out,
    output logic                not_keyed,
    output rc4_pkg::stat_t      stat
);

    localparam int unsigned KEY_AW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

    logic [7:0]        i_reg;
    logic [7:0]        i_next;
    logic [7:0]        j_reg;
    logic [7:0]        j_next;
    logic [KEY_AW-1:0] kpos_reg;
    logic [KEY_AW-1:0] kpos_next;
    logic              keyed_reg;
    logic              keyed_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [7:0]        si_reg;
    logic [7:0]        sj_reg;
    logic [7:0]        data_reg;
    logic [7:0]        data_out_reg;
    logic              not_keyed_reg;

    logic [7:0]        s_rd;
    logic [7:0]        s_raddr;
    logic [7:0]        s_waddr;
    logic [7:0]        s_wdata;
    logic [7:0]        k_rd;
    logic              k_we;
    logic [8:0]        len_eff;
    logic              k_wrap;
    logic              out_free;
    logic              out_load;

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (rc4_pkg::PERM_DEPTH)
    ) u_perm_ram (
        .clk   (clk),
        .we    (ctrl.s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .re    (ctrl.s_re),
        .raddr (s_raddr),
        .rdata (s_rd)
    );

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (KEY_BYTES)
    ) u_key_ram (
        .clk   (clk),
        .we    (k_we),
        .waddr (key_index[KEY_AW-1:0]),
        .wdata (byte_value),
        .re    (ctrl.k_re),
        .raddr (kpos_reg),
        .rdata (k_rd)
    );

    // Key loads beyond the store are dropped.
    assign k_we = in_accept && (rc4_pkg::kind_t'(kind) == rc4_pkg::KIND_KEY)
                  && ({1'b0, key_index} < 9'(KEY_BYTES));

    always_comb
    begin
        if (key_length == 9'd0)
        begin
            len_eff = 9'd1;
        end
        else if (key_length > 9'(KEY_BYTES))
        begin
            len_eff = 9'(KEY_BYTES);
        end
        else
        begin
            len_eff = key_length;
        end
    end

    assign k_wrap   = (kpos_reg == KEY_AW'(len_eff - 9'd1));
    assign out_free = !out_valid_reg || out_ready;
    assign out_load = (ctrl.out_sel != rc4_pkg::OUT_NONE) && out_free;

    always_comb
    begin
        case (ctrl.ra)
            rc4_pkg::RA_I:     s_raddr = i_reg;
            rc4_pkg::RA_I_INC: s_raddr = i_reg + 8'd1;
            rc4_pkg::RA_J:     s_raddr = j_reg;
            rc4_pkg::RA_J_SUM: s_raddr = j_reg + s_rd;
            rc4_pkg::RA_T:     s_raddr = si_reg + sj_reg;
            default:           s_raddr = i_reg;
        endcase

        s_waddr = (ctrl.wa == rc4_pkg::WA_J) ? j_reg : i_reg;

        case (ctrl.wd)
            rc4_pkg::WD_I:  s_wdata = i_reg;
            rc4_pkg::WD_RD: s_wdata = s_rd;
            rc4_pkg::WD_SI: s_wdata = si_reg;
            default:        s_wdata = s_rd;
        endcase
    end

    always_comb
    begin
        case (ctrl.i_op)
            rc4_pkg::I_INC: i_next = i_reg + 8'd1;
            rc4_pkg::I_CLR: i_next = 8'd0;
            default:        i_next = i_reg;
        endcase

        case (ctrl.j_op)
            rc4_pkg::J_CLR:  j_next = 8'd0;
            rc4_pkg::J_KS:   j_next = j_reg + s_rd + k_rd;
            rc4_pkg::J_CIPH: j_next = j_reg + s_rd;
            default:         j_next = j_reg;
        endcase

        case (ctrl.k_op)
            rc4_pkg::K_CLR: kpos_next = '0;
            rc4_pkg::K_INC: kpos_next = k_wrap ? '0 : kpos_reg + KEY_AW'(1);
            default:        kpos_next = kpos_reg;
        endcase

        keyed_next = keyed_reg || ctrl.set_keyed;

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= 8'd0;
            j_reg         <= 8'd0;
            kpos_reg      <= '0;
            keyed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            i_reg         <= i_next;
            j_reg         <= j_next;
            kpos_reg      <= kpos_next;
            keyed_reg     <= keyed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.si_ld)
        begin
            si_reg <= s_rd;
        end
        if (ctrl.sj_ld)
        begin
            sj_reg <= s_rd;
        end
        if (in_accept)
        begin
            data_reg <= byte_value;
        end
        if (out_load)
        begin
            data_out_reg  <= (ctrl.out_sel == rc4_pkg::OUT_CIPHER) ? (data_reg ^ s_rd)
                                                                   : data_reg;
            not_keyed_reg <= (ctrl.out_sel == rc4_pkg::OUT_PLAIN);
        end
    end

    assign out_valid     = out_valid_reg;
    assign data_out      = data_out_reg;
    assign not_keyed     = not_keyed_reg;
    assign stat.i_last   = (i_reg == 8'hFF);
    assign stat.keyed    = keyed_reg;
    assign stat.out_free = out_free;

endmodule

`default_nettype wire

// File: rtl/core/rc4_stream_cipher_unit.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit: RC4 stream cipher with a microcoded control unit.
// Key load: taken at dispatch with no further step. Data byte: swap and output
// steps, or only an output step when not yet keyed. Schedule: 256 fill steps and 256 swaps.
// One item at a time; schedule and data items share the single permutation RAM.
// Reset clears the indices, the keyed flag and the result valid flag; key_length
// returns to 16. The memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

// The unit is built from a small sequencer and a plain datapath. The
// sequencer holds a step counter and reads one control word per cycle from
// the microcode table in the package; the datapath does what that word says.
//
// Items are taken only while the sequencer sits at its dispatch step:
//   - a key byte is written straight into the key store on acceptance and
//     the unit is ready again in the next cycle;
//   - a schedule item first sweeps the permutation to the identity, one
//     entry a cycle, then runs 256 swaps, each made of these steps: read
//     S[i] and the key byte, update j, read S[j], write S[i], write S[j];
//   - a data item advances i, reads S[i], updates j and reads S[j], writes
//     the swapped pair and reads S[S[i]+S[j]] in the same cycle as the
//     second write, which the RAM's write-first read resolves correctly.
// A result sits in an output register, so the unit returns to dispatch and
// takes the next item while the consumer still holds the previous result.
// A new result waits at its final step only while the output register is
// still occupied and not being drained.

module rc4_stream_cipher_unit #(
    parameter int unsigned KEY_BYTES = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Item input channel.
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] kind,
    input  wire logic [7:0] key_index,
    input  wire logic [7:0] byte_value,
    // Result channel.
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] data_out,
    output logic            not_keyed,
    // Configuration write channel for the key length register.
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [8:0] cfg_data
);

    rc4_pkg::ctrl_t ctrl;
    rc4_pkg::stat_t stat;
    logic           in_accept;
    logic [8:0]     key_length_reg;
    logic [8:0]     key_length_next;

    // The register is always writable; writes must arrive only while idle, which the block does not enforce.
    assign cfg_ready       = 1'b1;
    assign key_length_next = (cfg_valid && cfg_ready) ? cfg_data : key_length_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_length_reg <= 9'd16;
        end
        else
        begin
            key_length_reg <= key_length_next;
        end
    end

    // The dispatch step is the only step that takes an item.
    assign in_ready  = ctrl.take;
    assign in_accept = in_valid && in_ready;

    rc4_sequencer u_sequencer (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .kind      (kind),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    rc4_datapath #(
        .KEY_BYTES (KEY_BYTES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .in_accept  (in_accept),
        .kind       (kind),
        .key_index  (key_index),
        .byte_value (byte_value),
        .key_length (key_length_reg),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .data_out   (data_out),
        .not_keyed  (not_keyed),
        .stat       (stat)
    );

    // A schedule item keeps the unit busy from the next cycle on.
    a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == rc4_pkg::KIND_SCHED)) |=> !in_ready)
        else $error("unit ready straight after a schedule item");

    // A keyed data item runs its swap steps before the next item is taken.
    a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (kind == rc4_pkg::KIND_DATA) && stat.keyed)
        |=> !in_ready)
        else $error("unit ready straight after a keyed data item");

    // Once keyed, the unit stays keyed until reset.
    a_keyed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(stat.keyed) |-> stat.keyed)
        else $error("keyed flag dropped without reset");

    // An enciphered result can only exist after a schedule has run.
    a_cipher_keyed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !not_keyed) |-> stat.keyed)
        else $error("enciphered result while not keyed");

endmodule

`default_nettype wire

// File: tb/rc4_stream_cipher_unit_test.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_unit_test: self-checking testbench of the RC4 cipher unit.
// The bench drives key loads, key schedules and data bytes through the item
// channel. A cipher model inside the bench predicts every result byte, and
// the bench checks each result against it in order. The key length register
// is moved through its extremes between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module rc4_stream_cipher_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    // Kind code 3 has no meaning to the unit; it must be dropped quietly.
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;
    localparam int unsigned STORE_DEPTH   = 256;
    localparam int unsigned TOTAL_ITEMS   = 900;
    // The longest quiet stretch in a correct run is the settling pause before
    // a register write, followed by a full key schedule. This limit allows
    // several of those.
    localparam int unsigned QUIET_LIMIT   = 10000;
    // The bench waits longer than a key schedule lasts before a register
    // write, because a schedule produces no result that would show when it
    // has finished.
    localparam int unsigned SETTLE_CYCLES = 1600;
    localparam int unsigned TAIL_CYCLES   = 20;
    localparam int unsigned MAX_REPORTS   = 100;

    typedef struct packed {
        logic [7:0] data;
        logic       unkeyed;
    } cipher_result_t;

    // ------------------------------------------------------------------------
    // Signals of the unit. All inputs hold known values from time zero.
    // ------------------------------------------------------------------------
    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       in_valid   = 1'b0;
    logic       in_ready;
    logic [1:0] kind       = 2'd0;
    logic [7:0] key_index  = 8'd0;
    logic [7:0] byte_value = 8'd0;
    logic       out_valid;
    logic       out_ready  = 1'b0;
    logic [7:0] data_out;
    logic       not_keyed;
    logic       cfg_valid  = 1'b0;
    logic       cfg_ready;
    logic [8:0] cfg_data   = 9'd0;

    rc4_stream_cipher_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .key_index  (key_index),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_out   (data_out),
        .not_keyed  (not_keyed),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Cipher model. This is the bench's own copy of the permutation, the key
    // store, both stream indices, the keyed flag and the key length register.
    // ------------------------------------------------------------------------
    logic [7:0]     perm_mdl [STORE_DEPTH];
    logic [7:0]     key_mdl  [STORE_DEPTH];
    bit             key_loaded [STORE_DEPTH];
    logic [7:0]     stream_i    = 8'd0;
    logic [7:0]     stream_j    = 8'd0;
    logic           keyed_mdl   = 1'b0;
    logic [8:0]     key_len_mdl = 9'd16;

    // Result bytes that are predicted but not yet seen, oldest first.
    cipher_result_t cipher_bytes_q[$];

    // Figures for the closing summary, the item count and the sender's burst state.
    int unsigned key_loads;
    int unsigned schedules;
    int unsigned data_items;
    int unsigned ignored_items;
    int unsigned length_writes;
    int unsigned checked_bytes;
    int unsigned failures;
    int unsigned items_done;
    int unsigned burst_left;

    // A length of zero acts as one. A length above the store size saturates.
    function automatic int unsigned key_span(logic [8:0] len);
        if (len == 9'd0)
            return 1;
        if (len > 9'(STORE_DEPTH))
            return STORE_DEPTH;
        return int'(len);
    endfunction

    task automatic rekey_permutation();
        int unsigned span;
        logic [7:0]  mix_j;
        logic [7:0]  held;
        span = key_span(key_len_mdl);
        for (int n = 0; n < STORE_DEPTH; n++)
            perm_mdl[n] = 8'(n);
        mix_j = 8'd0;
        for (int n = 0; n < STORE_DEPTH; n++)
        begin
            mix_j           = mix_j + perm_mdl[n] + key_mdl[n % span];
            held            = perm_mdl[n];
            perm_mdl[n]     = perm_mdl[mix_j];
            perm_mdl[mix_j] = held;
        end
        stream_i  = 8'd0;
        stream_j  = 8'd0;
        keyed_mdl = 1'b1;
    endtask

    // Brings the model up to date with one accepted item. Any result byte
    // that the item causes is queued for the checker.
    task automatic predict_item(input logic [1:0] k, input logic [7:0] idx,
                                input logic [7:0] val);
        cipher_result_t res;
        logic [7:0]     held;
        logic [7:0]     ks_pos;
        case (k)
            rc4_pkg::KIND_KEY:
            begin
                key_mdl[idx]    = val;
                key_loaded[idx] = 1'b1;
                key_loads++;
                items_done++;
            end
            rc4_pkg::KIND_SCHED:
            begin
                rekey_permutation();
                schedules++;
                items_done++;
            end
            rc4_pkg::KIND_DATA:
            begin
                if (!keyed_mdl)
                begin
                    // Before the first schedule the byte passes through unchanged.
                    res.data    = val;
                    res.unkeyed = 1'b1;
                end
                else
                begin
                    stream_i           = stream_i + 8'd1;
                    stream_j           = stream_j + perm_mdl[stream_i];
                    held               = perm_mdl[stream_i];
                    perm_mdl[stream_i] = perm_mdl[stream_j];
                    perm_mdl[stream_j] = held;
                    ks_pos             = perm_mdl[stream_i] + perm_mdl[stream_j];
                    res.data           = val ^ perm_mdl[ks_pos];
                    res.unkeyed        = 1'b0;
                end
                cipher_bytes_q.push_back(res);
                data_items++;
                items_done++;
            end
            default:
            begin
                ignored_items++;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Item sender. The sender works in bursts of random length. Between two
    // bursts it lowers valid for a random gap, but sometimes it skips the gap;
    // sometimes it runs a long burst. The task returns at the clock edge at
    // which the item was accepted, and valid is still high at that point. The
    // caller either drives the next item in the same step or lowers valid. In
    // both cases valid gets only one assignment in that step.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [1:0] k, input logic [7:0] idx,
                             input logic [7:0] val);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid   <= 1'b1;
        kind       <= k;
        key_index  <= idx;
        byte_value <= val;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_item(k, idx, val);
    endtask

    task automatic send_data_byte(input logic [7:0] val);
        send_item(rc4_pkg::KIND_DATA, 8'($urandom_range(0, 255)), val);
    endtask

    // A schedule must never read a key byte that was not written. For that
    // reason every store entry in the current span is loaded first.
    task automatic schedule_key();
        int unsigned span;
        span = key_span(key_len_mdl);
        for (int unsigned n = 0; n < span; n++)
            if (!key_loaded[n])
                send_item(rc4_pkg::KIND_KEY, 8'(n), 8'($urandom_range(0, 255)));
        send_item(rc4_pkg::KIND_SCHED, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    // The sender holds off until every predicted byte has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (cipher_bytes_q.size() != 0);
    endtask

    // Waits until the unit has drained, then gives a schedule that may still
    // be running the time it needs to finish. The register is only written
    // after this.
    task automatic drain_and_settle();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_key_length(input logic [8:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        key_len_mdl = len;
        length_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side. The receiver chooses a new stall mode whenever the low bits of
    // its cycle counter wrap to zero. The modes are: always ready, ready half the
    // time at random, a long stall with ready at a chance of one in eight, and a
    // fixed repeating on-off pattern. Each accepted result is checked at once
    // against the oldest prediction.
    // ------------------------------------------------------------------------
    logic [31:0] rx_cycle = '0;
    logic [1:0]  rx_mode  = 2'd0;

    always @(posedge clk)
    begin
        cipher_result_t want;
        rx_cycle <= rx_cycle + 32'd1;
        if (rx_cycle[6:0] == 7'd0)
            rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= 1'($urandom_range(0, 1));
            2'd2:    out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= (rx_cycle[2:0] < 3'd3);
        endcase

        if (rst_n && out_valid && out_ready)
        begin
            if (cipher_bytes_q.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: result %02h/%0b arrived with nothing expected",
                             $time, data_out, not_keyed);
            end
            else
            begin
                want = cipher_bytes_q.pop_front();
                checked_bytes++;
                if (data_out !== want.data)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("%0t: data_out expected %02h, actual %02h",
                                 $time, want.data, data_out);
                end
                if (not_keyed !== want.unkeyed)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("%0t: not_keyed expected %0b, actual %0b",
                                 $time, want.unkeyed, not_keyed);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. It counts the cycles in which no channel moves anything.
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no traffic for %0d cycles, giving up", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // This test runs before any schedule. Data bytes come back untouched and
    // carry the not-keyed flag. An item of the unused kind produces nothing.
    task automatic test_unkeyed_passthrough();
        send_data_byte(8'h00);
        send_item(KIND_UNUSED, 8'hFF, 8'hFF);
        send_data_byte(8'hFF);
        send_data_byte(8'hA5);
    endtask

    // This test keeps the key length of 16 from reset. The key bytes hold
    // both extremes. A load at the top of the store lies outside the span
    // and must leave the keystream alone.
    task automatic test_default_schedule();
        logic [7:0] pattern [16] = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'h55, 8'hAA, 8'h0F,
                                     8'hF0, 8'h3C, 8'hC3, 8'h99, 8'h66, 8'h12, 8'hED, 8'h5A};
        for (int n = 0; n < 16; n++)
            send_item(rc4_pkg::KIND_KEY, 8'(n), pattern[n]);
        send_item(rc4_pkg::KIND_KEY, 8'hFF, 8'hFF);
        schedule_key();
        send_data_byte(8'h00);
        send_data_byte(8'hFF);
        send_data_byte(8'h5A);
        send_data_byte(8'hA5);
    endtask

    // This test moves the key length to its corners. Zero acts as one. Values
    // beyond the store size saturate to the whole store. After each schedule
    // a few data bytes show the new keystream.
    task automatic test_key_length_extremes();
        logic [8:0] corners [4] = '{9'd0, 9'd1, 9'd511, 9'd256};
        foreach (corners[c])
        begin
            drain_and_settle();
            write_key_length(corners[c]);
            send_item(rc4_pkg::KIND_KEY, 8'h00, 8'($urandom_range(0, 255)));
            schedule_key();
            send_data_byte(8'($urandom_range(0, 255)));
            send_item(KIND_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            send_data_byte(8'($urandom_range(0, 255)));
            send_data_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Most of the traffic is well-formed: set a length, load some key bytes,
    // schedule, then send a run of data bytes. Mixed in with this is noise:
    // stray key loads that only count from the next schedule on, items of the
    // unused kind, re-keying in the middle of a stream, and pauses until the
    // results have drained. It runs until the whole run reaches its item count.
    task automatic test_random_traffic();
        int unsigned goal;
        int unsigned span;
        int unsigned pick;
        int unsigned run_len;
        logic [8:0]  len;
        goal = TOTAL_ITEMS;
        while (items_done < goal)
        begin
            pick = $urandom_range(0, 11);
            case (pick)
                0:       len = 9'd0;
                1:       len = 9'd1;
                2:       len = 9'd256;
                3:       len = 9'($urandom_range(257, 511));
                4, 5:    len = 9'($urandom_range(1, 256));
                default: len = 9'($urandom_range(1, 24));
            endcase
            drain_and_settle();
            write_key_length(len);
            span = key_span(len);
            repeat ($urandom_range(1, (span < 8) ? span : 8))
                send_item(rc4_pkg::KIND_KEY, 8'($urandom_range(0, span - 1)),
                          8'($urandom_range(0, 255)));
            schedule_key();

            run_len = $urandom_range(20, 60);
            repeat (run_len)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 4)
                    send_item(KIND_UNUSED, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                else if (pick < 9)
                    send_item(rc4_pkg::KIND_KEY, 8'($urandom_range(0, 255)),
                              8'($urandom_range(0, 255)));
                else if (pick < 10)
                    schedule_key();
                else if (pick < 12)
                    wait_for_results();
                else
                    send_data_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence of the run.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unkeyed_passthrough();
        test_default_schedule();
        test_key_length_extremes();
        test_random_traffic();

        // Let the last results come back, then wait TAIL_CYCLES more for anything
        // that should not come.
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d key loads, %0d schedules and %0d data bytes",
                 key_loads, schedules, data_items);
        $display("over %0d key length settings; %0d bytes checked, %0d unused-kind items.",
                 length_writes, checked_bytes, ignored_items);
        if (failures == 0 && cipher_bytes_q.size() == 0)
            $display("*** PASSED ***");
        else
        begin
            if (cipher_bytes_q.size() != 0)
                $display("%0t: %0d expected results never arrived",
                         $time, cipher_bytes_q.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/rc4_pkg.sv
rtl/core/rc4_ram.sv
rtl/core/rc4_sequencer.sv
rtl/core/rc4_datapath.sv
rtl/core/rc4_stream_cipher_unit.sv
tb/rc4_stream_cipher_unit_test.sv
